// ----- sv/spr_pkg.sv -----
// Shared constants, codes and types of the source position resolver.
// No dependencies; every other file but spr_ram imports this package.
package spr_pkg;

    localparam int MAX_FILES     = 16;
    localparam int FID_W         = $clog2(MAX_FILES);
    localparam int FCNT_W        = $clog2(MAX_FILES + 1);
    localparam int MAX_LINES     = 4096;
    localparam int LIDX_W        = $clog2(MAX_LINES);
    localparam int LFILL_W       = $clog2(MAX_LINES + 1);
    localparam int LCNT_W        = 13;
    localparam int FILE_LINE_CAP = 8191;
    localparam int POS_W         = 32;
    localparam int BYTE_W        = 8;
    localparam int CMD_W         = 2;

    localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'd10;

    localparam logic KIND_FILE    = 1'b0;
    localparam logic KIND_RESOLVE = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_BYTE    = 2'd0,
        CMD_EOF     = 2'd1,
        CMD_RESOLVE = 2'd2
    } spr_cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FSRCH,
        ST_FCMP,
        ST_FCHK,
        ST_LSRCH,
        ST_LCMP,
        ST_LFIN,
        ST_DONE
    } spr_state_t;

    typedef struct packed {
        logic [POS_W-1:0]  base;
        logic [POS_W-1:0]  size;
        logic [LIDX_W-1:0] first;
        logic [LCNT_W-1:0] count;
    } spr_file_ent_t;

    typedef struct packed {
        logic              kind;
        logic              found;
        logic [FID_W-1:0]  file_id;
        logic [POS_W-1:0]  file_base;
        logic [LCNT_W-1:0] line_number;
        logic [POS_W-1:0]  column_number;
        logic              overflow;
    } spr_result_t;

endpackage

// ----- sv/source_position_resolver.sv -----
// Top level of the source position resolver: file and line memories, the
// sequencer and the result output register. Uses spr_pkg, spr_ram and spr_ctrl.
//
// Files are registered by streaming their bytes (cmd 0) and closing them with
// an end-of-file transaction (cmd 1), which returns the file id, base, line
// count and size. A resolve transaction (cmd 2) maps a global position to file,
// line and column. The block takes one transaction at a time. A byte is taken
// without leaving the idle state; an end of file passes through the done state. A
// resolve runs two binary searches, each step being one read of a synchronous
// memory plus one compare, first over the registered files and then over the
// lines of the matched file. Position zero, or no file registered, skips both
// searches. A finished result moves into an output register, so the next
// transaction is taken while that result waits; if the register still holds an
// unread result, the sequencer holds its own result and takes no input until the
// register is read. The memories need no clearing after reset.
module source_position_resolver
    import spr_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [CMD_W-1:0]    s_cmd,
    input  logic [BYTE_W-1:0]   s_data_byte,
    input  logic [POS_W-1:0]    s_position,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_kind,
    output logic                m_found,
    output logic [FID_W-1:0]    m_file_id,
    output logic [POS_W-1:0]    m_file_base,
    output logic [LCNT_W-1:0]   m_line_number,
    output logic [POS_W-1:0]    m_column_number,
    output logic                m_overflow
);

    logic               fm_we;
    logic [FID_W-1:0]   fm_waddr;
    spr_file_ent_t      fm_wdata;
    logic               fm_re;
    logic [FID_W-1:0]   fm_raddr;
    spr_file_ent_t      fm_rdata;
    logic               lm_we;
    logic [LIDX_W-1:0]  lm_waddr;
    logic [POS_W-1:0]   lm_wdata;
    logic               lm_re;
    logic [LIDX_W-1:0]  lm_raddr;
    logic [POS_W-1:0]   lm_rdata;
    logic               res_valid;
    logic               res_ready;
    spr_result_t        res;

    logic               m_valid_reg, m_valid_next;
    spr_result_t        out_reg;

    spr_ram #(
        .WIDTH  ($bits(spr_file_ent_t)),
        .ADDR_W (FID_W)
    ) u_file_mem (
        .aclk  (aclk),
        .we    (fm_we),
        .waddr (fm_waddr),
        .wdata (fm_wdata),
        .re    (fm_re),
        .raddr (fm_raddr),
        .rdata (fm_rdata)
    );

    spr_ram #(
        .WIDTH  (POS_W),
        .ADDR_W (LIDX_W)
    ) u_line_mem (
        .aclk  (aclk),
        .we    (lm_we),
        .waddr (lm_waddr),
        .wdata (lm_wdata),
        .re    (lm_re),
        .raddr (lm_raddr),
        .rdata (lm_rdata)
    );

    spr_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (s_valid),
        .cmd_ready (s_ready),
        .cmd       (s_cmd),
        .data_byte (s_data_byte),
        .position  (s_position),
        .fm_we     (fm_we),
        .fm_waddr  (fm_waddr),
        .fm_wdata  (fm_wdata),
        .fm_re     (fm_re),
        .fm_raddr  (fm_raddr),
        .fm_rdata  (fm_rdata),
        .lm_we     (lm_we),
        .lm_waddr  (lm_waddr),
        .lm_wdata  (lm_wdata),
        .lm_re     (lm_re),
        .lm_raddr  (lm_raddr),
        .lm_rdata  (lm_rdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_kind          = out_reg.kind;
    assign m_found         = out_reg.found;
    assign m_file_id       = out_reg.file_id;
    assign m_file_base     = out_reg.file_base;
    assign m_line_number   = out_reg.line_number;
    assign m_column_number = out_reg.column_number;
    assign m_overflow      = out_reg.overflow;

endmodule

// ----- sv/spr_ram.sv -----
// Generic simple dual-port synchronous RAM with a registered read port.
// Used for the file table and the line start table; no dependencies.
module spr_ram #(
    parameter int WIDTH  = 32,
    parameter int ADDR_W = 12
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [(1 << ADDR_W)];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- sv/spr_ctrl.sv -----
// Sequencer of the source position resolver: file registration, line recording
// and the two binary searches over the file and line memories. Uses spr_pkg.
module spr_ctrl
    import spr_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  logic [CMD_W-1:0]    cmd,
    input  logic [BYTE_W-1:0]   data_byte,
    input  logic [POS_W-1:0]    position,
    output logic                fm_we,
    output logic [FID_W-1:0]    fm_waddr,
    output spr_file_ent_t       fm_wdata,
    output logic                fm_re,
    output logic [FID_W-1:0]    fm_raddr,
    input  spr_file_ent_t       fm_rdata,
    output logic                lm_we,
    output logic [LIDX_W-1:0]   lm_waddr,
    output logic [POS_W-1:0]    lm_wdata,
    output logic                lm_re,
    output logic [LIDX_W-1:0]   lm_raddr,
    input  logic [POS_W-1:0]    lm_rdata,
    output logic                res_valid,
    input  logic                res_ready,
    output spr_result_t         res
);

    spr_state_t state_reg, state_next;

    logic [FCNT_W-1:0]  files_reg, files_next;
    logic [POS_W-1:0]   gbase_reg, gbase_next;
    logic [POS_W-1:0]   cur_size_reg, cur_size_next;
    logic [LCNT_W-1:0]  cur_lines_reg, cur_lines_next;
    logic [LFILL_W-1:0] line_fill_reg, line_fill_next;
    logic               ovf_reg, ovf_next;

    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [LCNT_W-1:0]  lo_reg, lo_next;
    logic [LCNT_W-1:0]  hi_reg, hi_next;
    logic [FID_W-1:0]   id_reg, id_next;
    logic [POS_W-1:0]   base_reg, base_next;
    logic [POS_W-1:0]   local_reg, local_next;
    logic [LIDX_W-1:0]  first_reg, first_next;
    spr_result_t        res_reg, res_next;

    logic [LCNT_W-1:0]  mid;
    logic [LCNT_W-1:0]  lo_m1;
    logic               lo_lt_hi;
    logic               lo_zero;
    logic               skip_search;
    logic               pos_miss;
    logic [LCNT_W-1:0]  nl_count;
    logic [LFILL_W-1:0] new_first;
    logic [LCNT_W-1:0]  line_mid_addr;
    logic [LCNT_W-1:0]  line_last_addr;
    logic [POS_W-1:0]   start_clamped;
    spr_result_t        not_found;

    assign mid            = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign lo_m1          = lo_reg - LCNT_W'(1);
    assign lo_lt_hi       = lo_reg < hi_reg;
    assign lo_zero        = lo_reg == '0;
    assign skip_search    = (position == '0) || (files_reg == '0);
    assign pos_miss       = {1'b0, pos_reg} >= ({1'b0, fm_rdata.base} + {1'b0, fm_rdata.size});
    assign nl_count       = (fm_rdata.count == '0) ? '0 : fm_rdata.count - LCNT_W'(1);
    assign new_first      = line_fill_reg - LFILL_W'(cur_lines_reg);
    assign line_mid_addr  = LCNT_W'(first_reg) + mid;
    assign line_last_addr = LCNT_W'(first_reg) + lo_m1;
    assign start_clamped  = (lm_rdata > local_reg) ? local_reg : lm_rdata;

    always_comb begin
        not_found          = '0;
        not_found.kind     = KIND_RESOLVE;
        not_found.overflow = ovf_reg;
    end

    assign cmd_ready = state_reg == ST_IDLE;
    assign res_valid = state_reg == ST_DONE;
    assign res       = res_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    unique case (cmd)
                        CMD_EOF:     state_next = ST_DONE;
                        CMD_RESOLVE: state_next = skip_search ? ST_DONE : ST_FSRCH;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_FSRCH: begin
                if (lo_lt_hi) begin
                    state_next = ST_FCMP;
                end else if (lo_zero) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_FCHK;
                end
            end
            ST_FCMP: state_next = ST_FSRCH;
            ST_FCHK: state_next = pos_miss ? ST_DONE : ST_LSRCH;
            ST_LSRCH: begin
                if (lo_lt_hi) begin
                    state_next = ST_LCMP;
                end else if (lo_zero) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_LFIN;
                end
            end
            ST_LCMP: state_next = ST_LSRCH;
            ST_LFIN: state_next = ST_DONE;
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        files_next     = files_reg;
        gbase_next     = gbase_reg;
        cur_size_next  = cur_size_reg;
        cur_lines_next = cur_lines_reg;
        line_fill_next = line_fill_reg;
        ovf_next       = ovf_reg;
        pos_next       = pos_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        id_next        = id_reg;
        base_next      = base_reg;
        local_next     = local_reg;
        first_next     = first_reg;
        res_next       = res_reg;
        fm_we          = 1'b0;
        fm_waddr       = files_reg[FID_W-1:0];
        fm_wdata       = '0;
        fm_re          = 1'b0;
        fm_raddr       = mid[FID_W-1:0];
        lm_we          = 1'b0;
        lm_waddr       = line_fill_reg[LIDX_W-1:0];
        lm_wdata       = cur_size_reg + POS_W'(1);
        lm_re          = 1'b0;
        lm_raddr       = line_mid_addr[LIDX_W-1:0];

        unique case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    pos_next = position;
                    unique case (cmd)
                        CMD_BYTE: begin
                            if (cur_size_reg == '1) begin
                                ovf_next = 1'b1;
                            end else begin
                                if (data_byte == NEWLINE_BYTE &&
                                    files_reg < FCNT_W'(MAX_FILES)) begin
                                    if (line_fill_reg < LFILL_W'(MAX_LINES) &&
                                        cur_lines_reg < LCNT_W'(FILE_LINE_CAP - 1)) begin
                                        lm_we          = 1'b1;
                                        line_fill_next = line_fill_reg + LFILL_W'(1);
                                        cur_lines_next = cur_lines_reg + LCNT_W'(1);
                                    end else begin
                                        ovf_next = 1'b1;
                                    end
                                end
                                cur_size_next = cur_size_reg + POS_W'(1);
                            end
                        end
                        CMD_EOF: begin
                            if (files_reg >= FCNT_W'(MAX_FILES)) begin
                                ovf_next          = 1'b1;
                                res_next          = '0;
                                res_next.kind     = KIND_FILE;
                                res_next.overflow = 1'b1;
                            end else begin
                                fm_we                  = 1'b1;
                                fm_wdata.base          = gbase_reg;
                                fm_wdata.size          = cur_size_reg;
                                fm_wdata.first         = new_first[LIDX_W-1:0];
                                fm_wdata.count         = cur_lines_reg + LCNT_W'(1);
                                files_next             = files_reg + FCNT_W'(1);
                                gbase_next             = gbase_reg + cur_size_reg
                                                         + POS_W'(1);
                                res_next.kind          = KIND_FILE;
                                res_next.found         = 1'b1;
                                res_next.file_id       = files_reg[FID_W-1:0];
                                res_next.file_base     = gbase_reg;
                                res_next.line_number   = cur_lines_reg + LCNT_W'(1);
                                res_next.column_number = cur_size_reg;
                                res_next.overflow      = ovf_reg;
                            end
                            cur_size_next  = '0;
                            cur_lines_next = '0;
                        end
                        CMD_RESOLVE: begin
                            if (skip_search) begin
                                res_next = not_found;
                            end else begin
                                lo_next = '0;
                                hi_next = LCNT_W'(files_reg);
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_FSRCH: begin
                if (lo_lt_hi) begin
                    fm_re = 1'b1;
                end else if (lo_zero) begin
                    res_next = not_found;
                end else begin
                    fm_re    = 1'b1;
                    fm_raddr = lo_m1[FID_W-1:0];
                end
            end
            ST_FCMP: begin
                if (fm_rdata.base <= pos_reg) begin
                    lo_next = mid + LCNT_W'(1);
                end else begin
                    hi_next = mid;
                end
            end
            ST_FCHK: begin
                if (pos_miss) begin
                    res_next = not_found;
                end else begin
                    id_next    = lo_m1[FID_W-1:0];
                    base_next  = fm_rdata.base;
                    local_next = pos_reg - fm_rdata.base;
                    first_next = fm_rdata.first;
                    lo_next    = '0;
                    hi_next    = nl_count;
                end
            end
            ST_LSRCH: begin
                if (lo_lt_hi) begin
                    lm_re = 1'b1;
                end else if (lo_zero) begin
                    res_next.kind          = KIND_RESOLVE;
                    res_next.found         = 1'b1;
                    res_next.file_id       = id_reg;
                    res_next.file_base     = base_reg;
                    res_next.line_number   = LCNT_W'(1);
                    res_next.column_number = local_reg + POS_W'(1);
                    res_next.overflow      = ovf_reg;
                end else begin
                    lm_re    = 1'b1;
                    lm_raddr = line_last_addr[LIDX_W-1:0];
                end
            end
            ST_LCMP: begin
                if (lm_rdata <= local_reg) begin
                    lo_next = mid + LCNT_W'(1);
                end else begin
                    hi_next = mid;
                end
            end
            ST_LFIN: begin
                res_next.kind          = KIND_RESOLVE;
                res_next.found         = 1'b1;
                res_next.file_id       = id_reg;
                res_next.file_base     = base_reg;
                res_next.line_number   = lo_reg + LCNT_W'(1);
                res_next.column_number = local_reg - start_clamped + POS_W'(1);
                res_next.overflow      = ovf_reg;
            end
            ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            files_reg     <= '0;
            gbase_reg     <= POS_W'(1);
            cur_size_reg  <= '0;
            cur_lines_reg <= '0;
            line_fill_reg <= '0;
            ovf_reg       <= 1'b0;
        end else begin
            state_reg     <= state_next;
            files_reg     <= files_next;
            gbase_reg     <= gbase_next;
            cur_size_reg  <= cur_size_next;
            cur_lines_reg <= cur_lines_next;
            line_fill_reg <= line_fill_next;
            ovf_reg       <= ovf_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg   <= pos_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        id_reg    <= id_next;
        base_reg  <= base_next;
        local_reg <= local_next;
        first_reg <= first_next;
        res_reg   <= res_next;
    end

endmodule

// ----- dv/resolver_scoreboard_pkg.sv -----
// Scoreboard class for the source position resolver testbench: it predicts the
// file and line tables from accepted transactions and checks each result in order.
// Depends on spr_pkg for the widths, command codes and the result struct.
package resolver_scoreboard_pkg;
    import spr_pkg::*;

    class resolver_scoreboard;
        logic [POS_W-1:0]  f_base [MAX_FILES];
        logic [POS_W-1:0]  f_size [MAX_FILES];
        int unsigned       f_first [MAX_FILES];
        logic [LCNT_W-1:0] f_lines [MAX_FILES];
        logic [POS_W-1:0]  nl_start [MAX_LINES];

        int unsigned      nfiles;
        logic [POS_W-1:0] base_cursor;
        logic [POS_W-1:0] open_size;
        int unsigned      open_nl;
        int unsigned      lines_used;
        bit               ovf;

        spr_result_t awaited_results[$];
        int unsigned errors;

        function new();
            nfiles      = 0;
            base_cursor = 1;
            open_size   = '0;
            open_nl     = 0;
            lines_used  = 0;
            ovf         = 1'b0;
            errors      = 0;
        endfunction

        function logic [POS_W-1:0] line_at(int unsigned idx);
            return (idx < MAX_LINES) ? nl_start[idx] : '0;
        endfunction

        function void absorb_byte(logic [BYTE_W-1:0] data);
            if (open_size == '1) begin
                ovf = 1'b1;
                return;
            end
            if (data == NEWLINE_BYTE && nfiles < MAX_FILES) begin
                if (lines_used < MAX_LINES && open_nl + 1 < FILE_LINE_CAP) begin
                    nl_start[lines_used] = open_size + 1;
                    lines_used++;
                    open_nl++;
                end else begin
                    ovf = 1'b1;
                end
            end
            open_size++;
        endfunction

        function spr_result_t close_file();
            spr_result_t r;
            r      = '0;
            r.kind = KIND_FILE;
            if (nfiles >= MAX_FILES) begin
                ovf = 1'b1;
            end else begin
                f_base[nfiles]  = base_cursor;
                f_size[nfiles]  = open_size;
                f_first[nfiles] = lines_used - open_nl;
                f_lines[nfiles] = LCNT_W'(open_nl + 1);
                r.found         = 1'b1;
                r.file_id       = FID_W'(nfiles);
                r.file_base     = base_cursor;
                r.line_number   = f_lines[nfiles];
                r.column_number = open_size;
                base_cursor     = base_cursor + open_size + 1;
                nfiles++;
            end
            r.overflow = ovf;
            open_size  = '0;
            open_nl    = 0;
            return r;
        endfunction

        function spr_result_t lookup_position(logic [POS_W-1:0] pos);
            spr_result_t      r;
            int unsigned      lo, hi, mid, n, id, first, nl, k;
            logic [POS_W-1:0] offs, start;
            r          = '0;
            r.kind     = KIND_RESOLVE;
            r.overflow = ovf;
            n = (nfiles > MAX_FILES) ? MAX_FILES : nfiles;
            if (pos == '0 || n == 0) begin
                return r;
            end
            lo = 0;
            hi = n;
            while (lo < hi) begin
                mid = lo + (hi - lo) / 2;
                if (f_base[mid] <= pos) lo = mid + 1;
                else hi = mid;
            end
            if (lo == 0) begin
                return r;
            end
            id = lo - 1;
            if (33'(pos) >= 33'(f_base[id]) + 33'(f_size[id])) begin
                return r;
            end
            offs  = pos - f_base[id];
            first = f_first[id];
            nl    = (f_lines[id] != '0) ? f_lines[id] - 1 : 0;
            lo    = 0;
            hi    = nl;
            while (lo < hi) begin
                mid = lo + (hi - lo) / 2;
                if (line_at(first + mid) <= offs) lo = mid + 1;
                else hi = mid;
            end
            k     = lo;
            start = (k == 0) ? '0 : line_at(first + k - 1);
            if (start > offs) start = offs;
            r.found         = 1'b1;
            r.file_id       = FID_W'(id);
            r.file_base     = f_base[id];
            r.line_number   = LCNT_W'(k + 1);
            r.column_number = offs - start + 1;
            return r;
        endfunction

        function void note_input(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] data,
                                 logic [POS_W-1:0] pos);
            case (cmd)
                CMD_BYTE:    absorb_byte(data);
                CMD_EOF:     awaited_results.push_back(close_file());
                CMD_RESOLVE: awaited_results.push_back(lookup_position(pos));
                default:     ;
            endcase
        endfunction

        function void compare_field(string name, logic [POS_W-1:0] want,
                                    logic [POS_W-1:0] got, longint unsigned stamp);
            if (got !== want) begin
                $display("time %0d ns: %s mismatch, expected %0d, actual %0d",
                         stamp, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(spr_result_t got, longint unsigned stamp);
            spr_result_t want;
            if (awaited_results.size() == 0) begin
                $display("time %0d ns: result with nothing pending, expected none, actual %h",
                         stamp, got);
                errors++;
                return;
            end
            want = awaited_results.pop_front();
            compare_field("kind", POS_W'(want.kind), POS_W'(got.kind), stamp);
            compare_field("found", POS_W'(want.found), POS_W'(got.found), stamp);
            compare_field("file_id", POS_W'(want.file_id), POS_W'(got.file_id), stamp);
            compare_field("file_base", want.file_base, got.file_base, stamp);
            compare_field("line_number", POS_W'(want.line_number),
                          POS_W'(got.line_number), stamp);
            compare_field("column_number", want.column_number, got.column_number, stamp);
            compare_field("overflow", POS_W'(want.overflow), POS_W'(got.overflow), stamp);
        endfunction

        function int unsigned awaiting();
            return awaited_results.size();
        endfunction
    endclass

endpackage

// ----- dv/tb_source_position_resolver.sv -----
// Top-level testbench of the source position resolver: streams files, resolves
// positions under several pacing modes and checks every result transaction.
// Depends on spr_pkg, resolver_scoreboard_pkg and the source_position_resolver RTL.
module tb_source_position_resolver;
    timeunit 1ns;
    timeprecision 1ps;

    import spr_pkg::*;
    import resolver_scoreboard_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 100;
    localparam int RANDOM_PHASES  = 10;
    localparam int BIG_FILE_BYTES = 300;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef enum int {
        PACE_FREE,
        PACE_SEND_IDLE,
        PACE_RECV_STALL,
        PACE_BOTH
    } pace_t;

    logic                aclk;
    logic                aresetn         = 1'b0;
    logic                s_valid         = 1'b0;
    logic                s_ready;
    logic [CMD_W-1:0]    s_cmd           = '0;
    logic [BYTE_W-1:0]   s_data_byte     = '0;
    logic [POS_W-1:0]    s_position      = '0;
    logic                m_valid;
    logic                m_ready         = 1'b0;
    logic                m_kind;
    logic                m_found;
    logic [FID_W-1:0]    m_file_id;
    logic [POS_W-1:0]    m_file_base;
    logic [LCNT_W-1:0]   m_line_number;
    logic [POS_W-1:0]    m_column_number;
    logic                m_overflow;

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned quiet_cycles   = 0;

    resolver_scoreboard sb = new();

    source_position_resolver u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_data_byte     (s_data_byte),
        .s_position      (s_position),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_found         (m_found),
        .m_file_id       (m_file_id),
        .m_file_base     (m_file_base),
        .m_line_number   (m_line_number),
        .m_column_number (m_column_number),
        .m_overflow      (m_overflow)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        spr_result_t got;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                sb.note_input(s_cmd, s_data_byte, s_position);
            end
            if (m_valid && m_ready) begin
                got.kind          = m_kind;
                got.found         = m_found;
                got.file_id       = m_file_id;
                got.file_base     = m_file_base;
                got.line_number   = m_line_number;
                got.column_number = m_column_number;
                got.overflow      = m_overflow;
                sb.check_result(got, $time);
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("time %0d ns: no transaction for %0d cycles", $time, quiet_cycles);
                $display("tb_source_position_resolver: FAIL");
                $finish;
            end
        end
    end

    task automatic set_pace(input pace_t pace);
        case (pace)
            PACE_FREE: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            PACE_SEND_IDLE: begin
                send_idle_pct  = 73;
                recv_stall_pct = 0;
            end
            PACE_RECV_STALL: begin
                send_idle_pct  = 0;
                recv_stall_pct = 73;
            end
            default: begin
                send_idle_pct  = 22;
                recv_stall_pct = 22;
            end
        endcase
    endtask

    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] data,
                             input logic [POS_W-1:0] pos);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_cmd       <= cmd;
        s_data_byte <= data;
        s_position  <= pos;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_noise();
        send_item(CMD_UNUSED, 8'($urandom()), $urandom());
    endtask

    function automatic logic [BYTE_W-1:0] pick_byte(input int unsigned nl_pct);
        int unsigned r;
        r = $urandom_range(99, 0);
        if (r < nl_pct) return NEWLINE_BYTE;
        if (r < nl_pct + 15) return 8'($urandom());
        return 8'($urandom_range(126, 32));
    endfunction

    function automatic logic [POS_W-1:0] pick_position();
        int unsigned r, id;
        r = $urandom_range(99, 0);
        if (sb.nfiles == 0 || r < 15) return $urandom();
        if (r < 20) return '0;
        if (r < 30) return sb.base_cursor + $urandom_range(sb.open_size + 2, 0);
        id = $urandom_range(sb.nfiles - 1, 0);
        if (r < 36) return sb.f_base[id] - 1;
        return sb.f_base[id] + $urandom_range(sb.f_size[id], 0);
    endfunction

    task automatic resolve_burst(input int unsigned count);
        repeat (count) begin
            if ($urandom_range(99, 0) < 5) send_noise();
            send_item(CMD_RESOLVE, 8'($urandom()), pick_position());
        end
    endtask

    task automatic stream_file(input int unsigned len, input int unsigned nl_pct);
        int unsigned sent;
        int unsigned r;
        sent = 0;
        while (sent < len) begin
            r = $urandom_range(99, 0);
            if (r < 20) begin
                send_item(CMD_RESOLVE, 8'($urandom()), pick_position());
            end else if (r < 23) begin
                send_noise();
            end else begin
                send_item(CMD_BYTE, pick_byte(nl_pct), $urandom());
                sent++;
            end
        end
        send_item(CMD_EOF, 8'($urandom()), $urandom());
    endtask

    initial begin
        int unsigned      len;
        logic [POS_W-1:0] big_base;
        int unsigned      big_size;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Lookups before any file exists, then an empty file and a short one.
        set_pace(PACE_FREE);
        send_item(CMD_RESOLVE, 8'hFF, '0);
        send_item(CMD_RESOLVE, 8'h00, '1);
        send_item(CMD_UNUSED, 8'hFF, '1);
        send_item(CMD_EOF, 8'h00, '0);
        send_item(CMD_RESOLVE, 8'h00, 32'd1);
        send_item(CMD_BYTE, 8'h00, '1);
        send_item(CMD_BYTE, NEWLINE_BYTE, '0);
        send_item(CMD_BYTE, 8'hFF, '1);
        send_item(CMD_BYTE, NEWLINE_BYTE, '0);
        send_item(CMD_BYTE, NEWLINE_BYTE, '1);
        send_item(CMD_BYTE, 8'h61, '0);
        send_item(CMD_EOF, 8'hFF, '1);
        send_item(CMD_RESOLVE, 8'h00, 32'd2);
        send_item(CMD_RESOLVE, 8'h00, 32'd3);
        send_item(CMD_RESOLVE, 8'h00, 32'd4);
        send_item(CMD_RESOLVE, 8'h00, 32'd7);
        send_item(CMD_RESOLVE, 8'h00, 32'd8);
        send_item(CMD_RESOLVE, 8'h00, 32'd9);
        send_item(CMD_RESOLVE, 8'h00, '1);
        send_item(CMD_RESOLVE, 8'hFF, '0);

        for (int p = 1; p <= RANDOM_PHASES; p++) begin
            set_pace(pace_t'(p % 4));
            len = ($urandom_range(3, 0) == 0) ? $urandom_range(150, 40) : $urandom_range(30, 0);
            stream_file(len, 25);
            resolve_burst(40);
        end

        // One long file of mostly short lines gives the line search some depth.
        set_pace(PACE_BOTH);
        big_base = sb.base_cursor;
        big_size = 0;
        while (big_size < BIG_FILE_BYTES) begin
            if ($urandom_range(99, 0) < 10) begin
                send_item(CMD_RESOLVE, 8'($urandom()), pick_position());
            end else begin
                send_item(CMD_BYTE, pick_byte(85), $urandom());
                big_size++;
            end
        end
        send_item(CMD_EOF, 8'($urandom()), $urandom());
        repeat (20) begin
            send_item(CMD_RESOLVE, 8'($urandom()), big_base + big_size - $urandom_range(40, 1));
        end

        // Fill the file table, then offer files that do not fit.
        set_pace(PACE_SEND_IDLE);
        while (sb.nfiles < MAX_FILES) begin
            stream_file($urandom_range(20, 0), 25);
        end
        stream_file($urandom_range(20, 1), 30);
        stream_file(0, 0);

        for (int p = 0; p < 4; p++) begin
            set_pace(pace_t'(p));
            resolve_burst(100);
        end
        s_valid <= 1'b0;

        while (sb.awaiting() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sb.awaiting() != 0) begin
            $display("time %0d ns: %0d expected results never arrived", $time, sb.awaiting());
        end
        if (sb.errors == 0 && sb.awaiting() == 0) begin
            $display("tb_source_position_resolver: PASS");
        end else begin
            $display("tb_source_position_resolver: FAIL");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
sv/spr_pkg.sv
sv/spr_ram.sv
sv/spr_ctrl.sv
sv/source_position_resolver.sv
dv/resolver_scoreboard_pkg.sv
dv/tb_source_position_resolver.sv
